### rtl/least_request_backend_picker_assert.svh
// Assertion macros shared by the backend picker modules.
`ifndef LEAST_REQUEST_BACKEND_PICKER_ASSERT_SVH
`define LEAST_REQUEST_BACKEND_PICKER_ASSERT_SVH
`ifndef ASSERT_OFF
`define LRBP_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("lrbp assertion failed");
`define LRBP_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("lrbp assertion failed");
`else
`define LRBP_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define LRBP_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif
`endif

### rtl/lrbp_pkg.sv
// Shared constants, codes and controller/datapath interface types for the backend picker.
package lrbp_pkg;

  localparam int MAX_BACKENDS  = 16;
  localparam int IDX_W         = $clog2(MAX_BACKENDS);
  localparam int TOT_W         = $clog2(MAX_BACKENDS + 1);
  localparam int COUNT_BITS    = 16;
  localparam int WEIGHT_W      = 16;
  localparam int FRACTION_BITS = 16;
  localparam int NUM_W         = WEIGHT_W + FRACTION_BITS;
  localparam int BASE_W        = COUNT_BITS + 1;
  localparam int SUM_W         = NUM_W + IDX_W;
  localparam int RAND_W        = 16;
  localparam int BIAS_W        = 2;
  localparam int MODE_W        = 3;
  localparam int STATUS_W      = 3;
  localparam int LEVEL_W       = 16;
  localparam int DCNT_W        = $clog2(NUM_W);

  localparam logic [MODE_W-1:0] MODE_CHOOSE   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SENT     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FINISHED = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_CHOSEN  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NONE    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  localparam logic [BIAS_W-1:0] BIAS_RESET = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_EFF_ENTRY, S_DIV, S_EFF_STORE, S_EFF_END,
    S_WALK, S_SCAN, S_SCAN_END, S_CMP, S_FINISH
  } state_t;

  typedef enum logic [1:0] {RD_IDX, RD_BIDX, RD_A, RD_B} rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    exec;
    logic    pass_init;
    logic    idx_inc;
    logic    eff_begin;
    logic    div_step;
    logic    eff_write;
    logic    mul;
    logic    psel;
    logic    scan_step;
    logic    cap_a;
    logic    decide;
    logic    walk_step;
    logic    res_none;
    logic    out_load;
    rd_sel_t rd_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic is_choose;
    logic table_empty;
    logic weq;
    logic idx_last;
    logic w_zero;
    logic bias_zero;
    logic div_done;
    logic n_zero;
    logic total_zero;
    logic hit;
  } dp_sts_t;

endpackage

### rtl/least_request_backend_picker.sv
// Top level of the least-request backend picker.
// Table updates (add, sent, finished, clear) pass through the dispatch and finish states on
// the way to the result beat. A choose with equal weights scans the table once. A weighted
// choose first computes every effective weight with a one-bit-per-cycle divider, one division
// per power of the bias, then walks the table to the pick point. One item is worked on at a
// time; the result register lets the next item be accepted while the previous result beat
// still waits. The bias register resets to 1 and should be written only while no item is in
// flight.
module least_request_backend_picker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lrbp_pkg::MODE_W-1:0]     mode,
  input  logic [lrbp_pkg::IDX_W-1:0]      backend_index,
  input  logic [lrbp_pkg::WEIGHT_W-1:0]   weight,
  input  logic [lrbp_pkg::RAND_W-1:0]     rand_first,
  input  logic [lrbp_pkg::RAND_W-1:0]     rand_second,
  input  logic                            rand_tie,
  input  logic [lrbp_pkg::RAND_W-1:0]     rand_pick,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lrbp_pkg::STATUS_W-1:0]   status,
  output logic [lrbp_pkg::IDX_W-1:0]      chosen_index,
  output logic [lrbp_pkg::LEVEL_W-1:0]    active_level,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lrbp_pkg::BIAS_W-1:0]     cfg_data
);
  import lrbp_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  lrbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lrbp_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .mode          (mode),
    .backend_index (backend_index),
    .weight        (weight),
    .rand_first    (rand_first),
    .rand_second   (rand_second),
    .rand_tie      (rand_tie),
    .rand_pick     (rand_pick),
    .cfg_we        (cfg_valid),
    .cfg_bias      (cfg_data),
    .cmd           (cmd),
    .sts           (sts),
    .status        (status),
    .chosen_index  (chosen_index),
    .active_level  (active_level)
  );

endmodule

### rtl/lrbp_datapath.sv
// Backend table, effective-weight divider, pick multiplier and result registers.
`include "least_request_backend_picker_assert.svh"
module lrbp_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [lrbp_pkg::MODE_W-1:0]     mode,
  input  logic [lrbp_pkg::IDX_W-1:0]      backend_index,
  input  logic [lrbp_pkg::WEIGHT_W-1:0]   weight,
  input  logic [lrbp_pkg::RAND_W-1:0]     rand_first,
  input  logic [lrbp_pkg::RAND_W-1:0]     rand_second,
  input  logic                            rand_tie,
  input  logic [lrbp_pkg::RAND_W-1:0]     rand_pick,
  input  logic                            cfg_we,
  input  logic [lrbp_pkg::BIAS_W-1:0]     cfg_bias,
  input  lrbp_pkg::dp_cmd_t               cmd,
  output lrbp_pkg::dp_sts_t               sts,
  output logic [lrbp_pkg::STATUS_W-1:0]   status,
  output logic [lrbp_pkg::IDX_W-1:0]      chosen_index,
  output logic [lrbp_pkg::LEVEL_W-1:0]    active_level
);
  import lrbp_pkg::*;

  logic [BIAS_W-1:0]     bias;
  logic [MODE_W-1:0]     mode_q;
  logic [IDX_W-1:0]      bidx_q;
  logic [WEIGHT_W-1:0]   weight_q;
  logic [RAND_W-1:0]     rf_q, rs_q, rp_q;
  logic                  rt_q;

  logic [WEIGHT_W-1:0]   wt  [MAX_BACKENDS];
  logic [COUNT_BITS-1:0] cnt [MAX_BACKENDS];
  logic [NUM_W-1:0]      eff [MAX_BACKENDS];
  logic [TOT_W-1:0]      total_be;
  logic                  weq;

  logic [IDX_W-1:0]      idx;
  logic [TOT_W-1:0]      n_cnt;
  logic [SUM_W-1:0]      acc, pick, sum;
  logic [NUM_W-1:0]      quo;
  logic [BASE_W-1:0]     rem, base;
  logic [DCNT_W-1:0]     dcnt;
  logic [BIAS_W-1:0]     dleft;
  logic [IDX_W-1:0]      p1, p2, pa, pb, kk;
  logic                  n_one;
  logic [COUNT_BITS-1:0] ca;

  logic [STATUS_W-1:0]   res_status;
  logic [IDX_W-1:0]      res_idx;
  logic [LEVEL_W-1:0]    res_level;

  logic [IDX_W-1:0]        rd_addr;
  logic [COUNT_BITS-1:0]   cnt_rd, cnt_upd;
  logic [WEIGHT_W-1:0]     wt_rd;
  logic                    w_zero, full, unknown, match;
  logic [TOT_W-1:0]        n_eff, n_m1;
  logic [RAND_W+TOT_W-1:0] prod1, prod2;
  logic [IDX_W-1:0]        p1_c, r_c, p2_c;
  logic [BASE_W:0]         rem_sh, rem_sub;
  logic                    ge;
  logic [BASE_W-1:0]       rem_new;
  logic [SUM_W-1:0]        sum_next;
  logic [RAND_W+SUM_W-1:0] prod3;
  logic                    take_a;

  always_comb begin
    case (cmd.rd_sel)
      RD_IDX:  rd_addr = idx;
      RD_BIDX: rd_addr = bidx_q;
      RD_A:    rd_addr = pa;
      RD_B:    rd_addr = pb;
      default: rd_addr = idx;
    endcase
  end

  assign cnt_rd  = cnt[rd_addr];
  assign wt_rd   = wt[idx];
  assign w_zero  = (wt_rd == '0);
  assign full    = (total_be >= TOT_W'(MAX_BACKENDS));
  assign unknown = (TOT_W'(bidx_q) >= total_be);
  assign cnt_upd = (mode_q == MODE_SENT) ?
                   ((cnt_rd == '1) ? cnt_rd : cnt_rd + COUNT_BITS'(1)) :
                   ((cnt_rd == '0) ? cnt_rd : cnt_rd - COUNT_BITS'(1));

  // Candidate count is the whole table when weights match, else the nonzero-weight entries.
  assign n_eff = weq ? total_be : n_cnt;
  assign n_m1  = n_eff - TOT_W'(1);
  assign prod1 = (RAND_W+TOT_W)'(rf_q) * (RAND_W+TOT_W)'(n_eff);
  assign prod2 = (RAND_W+TOT_W)'(rs_q) * (RAND_W+TOT_W)'(n_m1);
  assign p1_c  = prod1[RAND_W +: IDX_W];
  assign r_c   = prod2[RAND_W +: IDX_W];
  assign p2_c  = (r_c < p1_c) ? r_c : r_c + IDX_W'(1);
  assign match = weq ? 1'b1 : !w_zero;

  // Restoring divider: quo shifts the dividend out and the quotient in.
  assign rem_sh  = {rem, quo[NUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, base});
  assign rem_sub = rem_sh - {1'b0, base};
  assign rem_new = ge ? rem_sub[BASE_W-1:0] : rem_sh[BASE_W-1:0];

  assign sum_next = sum + SUM_W'(eff[idx]);
  assign prod3    = (RAND_W+SUM_W)'(rp_q) * (RAND_W+SUM_W)'(acc);
  assign take_a   = n_one || (ca < cnt_rd) || ((ca == cnt_rd) && !rt_q);

  always_comb begin
    sts.is_choose   = (mode_q == MODE_CHOOSE);
    sts.table_empty = (total_be == '0);
    sts.weq         = weq;
    sts.idx_last    = ((TOT_W'(idx) + TOT_W'(1)) == total_be);
    sts.w_zero      = w_zero;
    sts.bias_zero   = (bias == '0);
    sts.div_done    = (dcnt == DCNT_W'(NUM_W-1)) && (dleft == BIAS_W'(1));
    sts.n_zero      = (n_cnt == '0);
    sts.total_zero  = (acc == '0);
    sts.hit         = (pick < sum_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bias     <= BIAS_RESET;
      total_be <= '0;
      weq      <= 1'b1;
    end else begin
      if (cfg_we) begin
        bias <= cfg_bias;
      end
      if (cmd.exec) begin
        case (mode_q)
          MODE_ADD: begin
            if (!full) begin
              total_be <= total_be + TOT_W'(1);
              weq      <= weq && ((total_be == '0) || (weight_q == wt[0]));
            end
          end
          MODE_CLEAR: begin
            total_be <= '0;
            weq      <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q   <= mode;
      bidx_q   <= backend_index;
      weight_q <= weight;
      rf_q     <= rand_first;
      rs_q     <= rand_second;
      rt_q     <= rand_tie;
      rp_q     <= rand_pick;
    end
    if (cmd.exec) begin
      case (mode_q)
        MODE_CHOOSE: begin
          res_status <= ST_NONE;
          res_idx    <= '0;
          res_level  <= '0;
        end
        MODE_ADD: begin
          res_level <= '0;
          if (full) begin
            res_status <= ST_FULL;
            res_idx    <= '0;
          end else begin
            res_status               <= ST_DONE;
            wt[total_be[IDX_W-1:0]]  <= weight_q;
            cnt[total_be[IDX_W-1:0]] <= '0;
            res_idx                  <= total_be[IDX_W-1:0];
          end
        end
        MODE_SENT, MODE_FINISHED: begin
          res_idx <= bidx_q;
          if (unknown) begin
            res_status <= ST_UNKNOWN;
            res_level  <= '0;
          end else begin
            res_status  <= ST_DONE;
            cnt[bidx_q] <= cnt_upd;
            res_level   <= LEVEL_W'(cnt_upd);
          end
        end
        default: begin
          res_status <= ST_DONE;
          res_idx    <= '0;
          res_level  <= '0;
        end
      endcase
    end
    if (cmd.res_none) begin
      res_status <= ST_NONE;
      res_idx    <= '0;
      res_level  <= '0;
    end
    if (cmd.pass_init) begin
      idx   <= '0;
      n_cnt <= '0;
      acc   <= '0;
    end
    if (cmd.idx_inc) begin
      idx <= idx + IDX_W'(1);
    end
    if (cmd.eff_begin) begin
      quo   <= w_zero ? '0 : {wt_rd, {FRACTION_BITS{1'b0}}};
      rem   <= '0;
      dcnt  <= '0;
      dleft <= bias;
      base  <= BASE_W'(cnt_rd) + BASE_W'(1);
    end
    if (cmd.div_step) begin
      quo <= {quo[NUM_W-2:0], ge};
      if (dcnt == DCNT_W'(NUM_W-1)) begin
        // One division is over; its quotient is the next dividend.
        rem   <= '0;
        dcnt  <= '0;
        dleft <= dleft - BIAS_W'(1);
      end else begin
        rem  <= rem_new;
        dcnt <= dcnt + DCNT_W'(1);
      end
    end
    if (cmd.eff_write) begin
      eff[idx] <= quo;
      acc      <= acc + SUM_W'(quo);
      if (!w_zero) begin
        n_cnt <= n_cnt + TOT_W'(1);
      end
    end
    if (cmd.mul) begin
      pick <= prod3[RAND_W +: SUM_W];
      sum  <= '0;
      idx  <= '0;
    end
    if (cmd.walk_step) begin
      sum <= sum_next;
      if (pick < sum_next) begin
        res_status <= ST_CHOSEN;
        res_idx    <= idx;
        res_level  <= LEVEL_W'(cnt_rd);
      end
    end
    if (cmd.psel) begin
      p1    <= p1_c;
      p2    <= p2_c;
      n_one <= (n_eff == TOT_W'(1));
      idx   <= '0;
      kk    <= '0;
    end
    if (cmd.scan_step && match) begin
      if (kk == p1) begin
        pa <= idx;
      end
      if (kk == p2) begin
        pb <= idx;
      end
      kk <= kk + IDX_W'(1);
    end
    if (cmd.cap_a) begin
      ca <= cnt_rd;
    end
    if (cmd.decide) begin
      res_status <= ST_CHOSEN;
      res_idx    <= take_a ? pa : pb;
      res_level  <= LEVEL_W'(take_a ? ca : cnt_rd);
    end
    if (cmd.out_load) begin
      status       <= res_status;
      chosen_index <= res_idx;
      active_level <= res_level;
    end
  end

  `LRBP_ASSERT_IMP(a_empty_means_equal, clk, rst, total_be == '0, weq)

endmodule

### rtl/lrbp_ctrl.sv
// Controller state machine that sequences table updates, weighted passes and two-choice picks.
`include "least_request_backend_picker_assert.svh"
module lrbp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  lrbp_pkg::dp_sts_t sts,
  output lrbp_pkg::dp_cmd_t cmd
);
  import lrbp_pkg::*;

  state_t state, state_next;
  logic   accept, out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (!sts.is_choose || sts.table_empty) state_next = S_FINISH;
        else if (sts.weq)                      state_next = S_SCAN;
        else                                   state_next = S_EFF_ENTRY;
      end
      S_EFF_ENTRY: begin
        if (sts.w_zero || sts.bias_zero) state_next = S_EFF_STORE;
        else                             state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_EFF_STORE;
      end
      S_EFF_STORE: begin
        if (sts.idx_last) state_next = S_EFF_END;
        else              state_next = S_EFF_ENTRY;
      end
      S_EFF_END: begin
        if (sts.n_zero)          state_next = S_FINISH;
        else if (sts.total_zero) state_next = S_SCAN;
        else                     state_next = S_WALK;
      end
      S_WALK: begin
        if (sts.hit || sts.idx_last) state_next = S_FINISH;
      end
      S_SCAN: begin
        if (sts.idx_last) state_next = S_SCAN_END;
      end
      S_SCAN_END: state_next = S_CMP;
      S_CMP:      state_next = S_FINISH;
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_IDX;
    case (state)
      S_IDLE: cmd.load = accept;
      S_DISPATCH: begin
        cmd.rd_sel = RD_BIDX;
        if (!sts.is_choose || sts.table_empty) cmd.exec = 1'b1;
        else if (sts.weq)                      cmd.psel = 1'b1;
        else                                   cmd.pass_init = 1'b1;
      end
      S_EFF_ENTRY: cmd.eff_begin = 1'b1;
      S_DIV:       cmd.div_step = 1'b1;
      S_EFF_STORE: begin
        cmd.eff_write = 1'b1;
        cmd.idx_inc   = !sts.idx_last;
      end
      S_EFF_END: begin
        if (sts.n_zero)          cmd.res_none = 1'b1;
        else if (sts.total_zero) cmd.psel = 1'b1;
        else                     cmd.mul = 1'b1;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        cmd.idx_inc   = !sts.hit;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.idx_inc   = !sts.idx_last;
      end
      S_SCAN_END: begin
        cmd.rd_sel = RD_A;
        cmd.cap_a  = 1'b1;
      end
      S_CMP: begin
        cmd.rd_sel = RD_B;
        cmd.decide = 1'b1;
      end
      S_FINISH: cmd.out_load = out_free;
      default: ;
    endcase
  end

  `LRBP_ASSERT_IMP(a_load_when_free, clk, rst, cmd.out_load, !out_valid || out_ready)
  `LRBP_ASSERT_NXT(a_accept_dispatch, clk, rst, accept, state == S_DISPATCH)
  `LRBP_ASSERT_IMP(a_valid_from_finish, clk, rst, $rose(out_valid), $past(state) == S_FINISH)

endmodule

### tb/tb_least_request_backend_picker.sv
// Randomized self-checking testbench for the least-request backend picker.
module tb_least_request_backend_picker;
  timeunit 1ns;
  timeprecision 1ps;
  import lrbp_pkg::*;

  typedef struct {
    logic [MODE_W-1:0]   mode;
    logic [IDX_W-1:0]    bidx;
    logic [WEIGHT_W-1:0] weight;
    logic [RAND_W-1:0]   r_first;
    logic [RAND_W-1:0]   r_second;
    logic                r_tie;
    logic [RAND_W-1:0]   r_pick;
  } request_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    index;
    logic [LEVEL_W-1:0]  level;
  } answer_t;

  class picker_scoreboard;
    logic [WEIGHT_W-1:0]   weights [MAX_BACKENDS];
    logic [COUNT_BITS-1:0] counts [MAX_BACKENDS];
    int unsigned           used;
    bit                    all_equal;
    int unsigned           bias_now;
    answer_t               pending [$];
    int unsigned           errors;
    int unsigned           checked;
    int unsigned           weighted_picks;
    int unsigned           p2c_picks;

    function new();
      used = 0;
      all_equal = 1;
      bias_now = BIAS_RESET;
      errors = 0;
      checked = 0;
      weighted_picks = 0;
      p2c_picks = 0;
    endfunction

    function int unsigned two_choices(int unsigned cand[$], request_t rq);
      int unsigned n, p1, r, p2, a, b;
      n = cand.size();
      if (n == 1) return cand[0];
      p1 = 32'((longint'(rq.r_first) * n) >> 16);
      r = 32'((longint'(rq.r_second) * (n - 1)) >> 16);
      p2 = (r < p1) ? r : r + 1;
      a = cand[p1];
      b = cand[p2];
      if (counts[a] < counts[b]) return a;
      if (counts[b] < counts[a]) return b;
      return rq.r_tie ? b : a;
    endfunction

    // Saturating (count+1)^bias; the divisor only matters up to num+1.
    function longint unsigned scaled_weight(int unsigned i);
      longint unsigned num, base, d;
      num = longint'(weights[i]) << FRACTION_BITS;
      base = longint'(counts[i]) + 1;
      d = 1;
      for (int k = 0; k < bias_now; k++) begin
        if (d > num / base) d = num + 1;
        else d = d * base;
      end
      return num / d;
    endfunction

    function void note_request(request_t rq);
      answer_t ans;
      int unsigned cand[$];
      longint unsigned eff[$];
      longint unsigned total, pick, sum;
      int unsigned pos;
      ans = '{ST_DONE, '0, '0};
      if (rq.mode == MODE_CHOOSE) begin
        if (used == 0) begin
          ans.status = ST_NONE;
        end else if (all_equal) begin
          for (int i = 0; i < used; i++) cand = {cand, i};
          ans.status = ST_CHOSEN;
          ans.index = IDX_W'(two_choices(cand, rq));
          p2c_picks++;
        end else begin
          total = 0;
          for (int i = 0; i < used; i++) begin
            if (weights[i] != 0) begin
              cand = {cand, i};
              eff = {eff, scaled_weight(i)};
              total += eff[$];
            end
          end
          if (cand.size() == 0) begin
            ans.status = ST_NONE;
          end else if (total == 0) begin
            ans.status = ST_CHOSEN;
            ans.index = IDX_W'(two_choices(cand, rq));
            p2c_picks++;
          end else begin
            pick = (longint'(rq.r_pick) * total) >> 16;
            sum = 0;
            pos = cand.size() - 1;
            for (int i = 0; i < cand.size(); i++) begin
              sum += eff[i];
              if (pick < sum) begin
                pos = i;
                break;
              end
            end
            ans.status = ST_CHOSEN;
            ans.index = IDX_W'(cand[pos]);
            weighted_picks++;
          end
        end
        if (ans.status == ST_CHOSEN) ans.level = counts[ans.index];
      end else if (rq.mode == MODE_ADD) begin
        if (used >= MAX_BACKENDS) begin
          ans.status = ST_FULL;
        end else begin
          ans.index = IDX_W'(used);
          weights[used] = rq.weight;
          counts[used] = '0;
          used++;
          all_equal = 1;
          for (int i = 1; i < used; i++)
            if (weights[i] != weights[0]) all_equal = 0;
        end
      end else if (rq.mode == MODE_SENT || rq.mode == MODE_FINISHED) begin
        ans.index = rq.bidx;
        if (rq.bidx >= used) begin
          ans.status = ST_UNKNOWN;
        end else begin
          if (rq.mode == MODE_SENT) begin
            if (counts[rq.bidx] != '1) counts[rq.bidx]++;
          end else if (counts[rq.bidx] != 0) begin
            counts[rq.bidx]--;
          end
          ans.level = counts[rq.bidx];
        end
      end else if (rq.mode == MODE_CLEAR) begin
        used = 0;
        all_equal = 1;
      end
      pending = {pending, ans};
    endfunction

    function void check_answer(answer_t got);
      answer_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat status=%0d index=%0d level=%0d",
                 $time, got.status, got.index, got.level);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.index !== want.index) begin
        $display("%0t: chosen_index expected %0d actual %0d", $time, want.index, got.index);
        errors++;
      end
      if (got.level !== want.level) begin
        $display("%0t: active_level expected %0d actual %0d", $time, want.level, got.level);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [MODE_W-1:0]   mode;
  logic [IDX_W-1:0]    backend_index;
  logic [WEIGHT_W-1:0] weight;
  logic [RAND_W-1:0]   rand_first;
  logic [RAND_W-1:0]   rand_second;
  logic                rand_tie;
  logic [RAND_W-1:0]   rand_pick;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    chosen_index;
  logic [LEVEL_W-1:0]  active_level;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [BIAS_W-1:0]   cfg_data;

  picker_scoreboard board;

  least_request_backend_picker dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .backend_index(backend_index), .weight(weight),
    .rand_first(rand_first), .rand_second(rand_second), .rand_tie(rand_tie),
    .rand_pick(rand_pick),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .chosen_index(chosen_index), .active_level(active_level),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int unsigned gap_length();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  task automatic idle_cycles(int unsigned n);
    repeat (n) @(negedge clk);
  endtask

  // The block takes no new item until it returns to idle, so valid drops after every accepted item.
  task automatic send_request(request_t rq, bit with_gaps);
    if (with_gaps) idle_cycles(gap_length());
    @(negedge clk);
    mode <= rq.mode;
    backend_index <= rq.bidx;
    weight <= rq.weight;
    rand_first <= rq.r_first;
    rand_second <= rq.r_second;
    rand_tie <= rq.r_tie;
    rand_pick <= rq.r_pick;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    board.note_request(rq);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (board.pending.size() != 0) @(negedge clk);
    idle_cycles(50);
  endtask

  task automatic write_bias(logic [BIAS_W-1:0] value);
    wait_drained();
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    board.bias_now = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic request_t random_request(int unsigned kind);
    request_t rq;
    rq.mode = MODE_W'(kind);
    rq.bidx = IDX_W'($urandom_range(15));
    rq.weight = WEIGHT_W'($urandom);
    rq.r_first = RAND_W'($urandom);
    rq.r_second = RAND_W'($urandom);
    rq.r_tie = 1'($urandom_range(1));
    rq.r_pick = RAND_W'($urandom);
    return rq;
  endfunction

  // One well-formed session: clear, fill with a weight pattern, then traffic.
  task automatic run_session(int unsigned items);
    request_t    rq;
    int unsigned fill, style, roll;
    logic [WEIGHT_W-1:0] same;
    fill = ($urandom_range(9) == 0) ? MAX_BACKENDS : $urandom_range(6, 1);
    style = $urandom_range(4);
    same = ($urandom_range(3) == 0) ? 16'd0 : WEIGHT_W'($urandom);
    send_request(random_request(MODE_CLEAR), 1);
    for (int i = 0; i < fill; i++) begin
      rq = random_request(MODE_ADD);
      case (style)
        0: rq.weight = same;
        1: rq.weight = WEIGHT_W'($urandom_range(4));
        2: rq.weight = ($urandom_range(3) == 0) ? 16'hFFFF :
                       WEIGHT_W'($urandom_range(100, 1));
        default: rq.weight = WEIGHT_W'($urandom);
      endcase
      send_request(rq, 1);
    end
    for (int i = 0; i < items; i++) begin
      roll = $urandom_range(99);
      if (roll < 40) rq = random_request(MODE_CHOOSE);
      else if (roll < 70) rq = random_request(MODE_SENT);
      else if (roll < 88) rq = random_request(MODE_FINISHED);
      else if (roll < 94) rq = random_request(MODE_ADD);
      else rq = random_request($urandom_range(7));
      if (rq.mode inside {MODE_SENT, MODE_FINISHED} && $urandom_range(9) != 0)
        rq.bidx = IDX_W'($urandom_range(fill - 1));
      send_request(rq, 1);
    end
  endtask

  task automatic directed_part();
    request_t rq;
    send_request(random_request(MODE_CHOOSE), 0);      // empty table
    send_request(random_request(MODE_SENT), 0);        // unknown index
    rq = random_request(MODE_ADD);
    rq.weight = 16'hFFFF;
    send_request(rq, 0);
    rq = random_request(MODE_CHOOSE);
    send_request(rq, 0);                                // single candidate
    rq = random_request(MODE_FINISHED);
    rq.bidx = '0;
    send_request(rq, 0);                                // floor at zero
    rq = random_request(MODE_ADD);
    rq.weight = 16'hFFFF;
    send_request(rq, 0);
    rq = random_request(MODE_CHOOSE);
    rq.r_first = 16'h0000;
    rq.r_second = 16'hFFFF;
    rq.r_tie = 1'b1;
    send_request(rq, 0);                                // tie taking the second
    rq.r_first = 16'hFFFF;
    rq.r_second = 16'h0000;
    rq.r_tie = 1'b0;
    send_request(rq, 0);
    rq = random_request(MODE_ADD);
    rq.weight = 16'h0000;
    send_request(rq, 0);                                // unequal weights now
    rq = random_request(MODE_CHOOSE);
    rq.r_pick = 16'h0000;
    send_request(rq, 0);
    rq.r_pick = 16'hFFFF;
    send_request(rq, 0);
    rq = random_request(MODE_SENT);
    rq.bidx = 4'd15;
    send_request(rq, 0);
    for (int i = 0; i < 14; i++) send_request(random_request(MODE_ADD), 0);
    send_request(random_request(MODE_ADD), 0);         // table full
    send_request(random_request(3'd7), 0);              // unused mode
    send_request(random_request(MODE_CLEAR), 0);
    // One zero and one nonzero weight: only the nonzero-weight backend is eligible.
    rq = random_request(MODE_ADD);
    rq.weight = 16'd0;
    send_request(rq, 0);
    rq.weight = 16'd1;
    send_request(rq, 0);
    rq = random_request(MODE_CHOOSE);
    send_request(rq, 0);
  endtask

  // Drives one backend's count well above the others, then picks with bias zero.
  task automatic saturate_count();
    request_t rq;
    send_request(random_request(MODE_CLEAR), 0);
    rq = random_request(MODE_ADD);
    rq.weight = 16'd1;
    send_request(rq, 0);
    rq.weight = 16'd2;
    send_request(rq, 0);
    rq = random_request(MODE_SENT);
    rq.bidx = '0;
    repeat (100) send_request(rq, 0);
    rq = random_request(MODE_CHOOSE);
    send_request(rq, 0);
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    mode = '0;
    backend_index = '0;
    weight = '0;
    rand_first = '0;
    rand_second = '0;
    rand_tie = 1'b0;
    rand_pick = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    directed_part();
    write_bias(2'd0);
    saturate_count();
    write_bias(2'd3);
    run_session(15);
    for (int s = 0; s < 32; s++) begin
      if (s % 8 == 0) write_bias(BIAS_W'($urandom_range(3)));
      run_session($urandom_range(30, 10));
    end
    write_bias(2'd0);
    run_session(30);
    write_bias(2'd1);
    run_session(30);
    wait_drained();
    $display("Checked %0d result beats: %0d weighted picks, %0d two-choice picks,",
             board.checked, board.weighted_picks, board.p2c_picks);
    $display("over bias settings 0 to 3, full and empty tables and the count floor.");
    if (board.errors == 0) begin
      $display("least_request_backend_picker verification clean");
    end else begin
      $display("least_request_backend_picker verification failed");
    end
    $finish;
  end

  // Result side: random stalls, with long runs of steady acceptance.
  initial begin
    int unsigned stall;
    @(negedge clk);
    forever begin
      if ($urandom_range(3) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(40, 5)) @(negedge clk);
      end else begin
        stall = gap_length();
        out_ready <= (stall == 0);
        if (stall != 0) idle_cycles(stall);
        else @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_answer('{status, chosen_index, active_level});
  end

  initial begin
    #100ms;
    $display("least_request_backend_picker verification failed");
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl
rtl/lrbp_pkg.sv
rtl/lrbp_datapath.sv
rtl/lrbp_ctrl.sv
rtl/least_request_backend_picker.sv
tb/tb_least_request_backend_picker.sv
